// ===== sv/hmm_scaled_forward_recursion_unit_macros.svh =====
// Assertion macros for the scaled forward recursion unit.
// Used by the top level only; depends on nothing else.
`ifndef HMM_SCALED_FORWARD_RECURSION_UNIT_MACROS_SVH
`define HMM_SCALED_FORWARD_RECURSION_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSFR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HSFR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/hsfr_pkg.sv =====
// Shared types and constants of the scaled forward recursion unit.
// Used by hsfr_cell and the top level; depends on nothing.
package hsfr_pkg;

   // Fixed widths of the request, response and CSR fields.
   localparam int OPCODE_W = 2;
   localparam int ROW_W    = 3;
   localparam int COL_W    = 4;
   localparam int SYM_W    = 4;
   localparam int CSR_W    = 4;
   localparam int SCALE_W  = 16;

   // Depth of the product pipeline inside a cell, from captured alpha to accumulator.
   localparam int PIPE_DEPTH = 5;

   localparam logic [OPCODE_W-1:0] OP_LOAD_TRAN = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD_EMIS = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_OBSERVE   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIS,
      ST_RUN,
      ST_DRAIN,
      ST_WB,
      ST_SUM,
      ST_SCALE,
      ST_OUT
   } state_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic load_tran;
      logic load_emis;
      logic emis_rd;
      logic clear;
      logic run;
      logic rotate;
      logic wb;
      logic rescale;
      logic first;
      logic sym_ok;
   } cell_ctl_type;

endpackage

// ===== sv/hsfr_cell.sv =====
// One destination-state cell: its transition column, emission row, alpha and
// product pipeline. Depends on hsfr_pkg.
module hsfr_cell #(
   parameter int N_STATES    = 8,
   parameter int N_SYMBOLS   = 16,
   parameter int SCALE_SHIFT = 16,
   parameter int PROB_BITS   = 32,
   parameter int CELL_IDX    = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  hsfr_pkg::cell_ctl_type          ctl,
   input  logic [$clog2(N_STATES)-1:0]     step_k,
   input  logic [$clog2(N_STATES+1)-1:0]   n_active,
   input  logic [hsfr_pkg::ROW_W-1:0]      wr_row,
   input  logic [hsfr_pkg::COL_W-1:0]      wr_col,
   input  logic [PROB_BITS-1:0]            wr_prob,
   input  logic [$clog2(N_SYMBOLS)-1:0]    rd_sym,
   input  logic [PROB_BITS+7:0]            alpha_in,
   output logic [PROB_BITS+7:0]            alpha_out
);

   localparam int PB    = PROB_BITS;
   localparam int AW    = PROB_BITS + 8;
   localparam int KW    = $clog2(N_STATES);
   localparam int TA_W  = $clog2(N_STATES);
   localparam int SA_W  = $clog2(N_SYMBOLS);
   localparam int ACC_W = AW + KW;

   logic [PB-1:0]    tran_mem [N_STATES];
   logic [PB-1:0]    emis_mem [N_SYMBOLS];
   logic [PB-1:0]    tran_rd_ff;
   logic [PB-1:0]    emis_rd_ff;

   logic [KW:0]      src_sum;
   logic [KW-1:0]    src;
   logic             src_use;
   logic             cell_active;
   logic             tran_we;
   logic             emis_we;
   logic [PB-1:0]    emis_b;

   logic [AW-1:0]    alpha_ff,   alpha_in_nx;
   logic [AW-1:0]    s1_alpha_ff;
   logic             s1_valid_ff;
   logic [2*PB-1:0]  s2_plo_ff,  s2_plo_in;
   logic [AW-1:0]    s2_phi_ff,  s2_phi_in;
   logic             s2_valid_ff;
   logic [AW-1:0]    s3_t_ff,    s3_t_in;
   logic             s3_valid_ff;
   logic [2*PB-1:0]  s4_qlo_ff,  s4_qlo_in;
   logic [AW-1:0]    s4_qhi_ff,  s4_qhi_in;
   logic             s4_valid_ff;
   logic [AW-1:0]    s5_term_ff, s5_term_in;
   logic             s5_valid_ff;
   logic [ACC_W-1:0] acc_ff,     acc_in;
   logic [AW-1:0]    acc_sat;
   logic [AW-1:0]    new_alpha;

   // Source state seen this cycle: the alpha ring has turned step_k places.
   always_comb begin
      src_sum = {1'b0, step_k} + (KW+1)'(CELL_IDX);
      if (32'(src_sum) >= N_STATES) begin
         src_sum = src_sum - (KW+1)'(N_STATES);
      end
      src = src_sum[KW-1:0];
   end

   assign src_use     = 32'(src) < 32'(n_active);
   assign cell_active = 32'(CELL_IDX) < 32'(n_active);
   assign tran_we     = ctl.load_tran && (32'(wr_col) == CELL_IDX);
   assign emis_we     = ctl.load_emis && (32'(wr_row) == CELL_IDX);
   assign emis_b      = ctl.sym_ok ? emis_rd_ff : '0;

   // Transition column of this destination state, read once per ring step.
   always_ff @(posedge clock) begin
      if (tran_we) begin
         tran_mem[TA_W'(wr_row)] <= wr_prob;
      end
      tran_rd_ff <= tran_mem[src];
   end

   // Emission row of this state, read once per observed symbol.
   always_ff @(posedge clock) begin
      if (emis_we) begin
         emis_mem[SA_W'(wr_col)] <= wr_prob;
      end
      if (ctl.emis_rd) begin
         emis_rd_ff <= emis_mem[rd_sym];
      end
   end

   // Product pipeline: alpha times transition, then times emission, each split
   // into a low and a high partial product and recombined a stage later.
   always_comb begin
      s2_plo_in  = s1_alpha_ff[PB-1:0] * tran_rd_ff;
      s2_phi_in  = s1_alpha_ff[AW-1:PB] * tran_rd_ff;
      s3_t_in    = s2_phi_ff + AW'(s2_plo_ff[2*PB-1:PB]);
      s4_qlo_in  = s3_t_ff[PB-1:0] * emis_b;
      s4_qhi_in  = s3_t_ff[AW-1:PB] * emis_b;
      s5_term_in = s4_qhi_ff + AW'(s4_qlo_ff[2*PB-1:PB]);
   end

   always_ff @(posedge clock) begin
      s1_alpha_ff <= alpha_ff;
      s2_plo_ff   <= s2_plo_in;
      s2_phi_ff   <= s2_phi_in;
      s3_t_ff     <= s3_t_in;
      s4_qlo_ff   <= s4_qlo_in;
      s4_qhi_ff   <= s4_qhi_in;
      s5_term_ff  <= s5_term_in;
   end

   // Valid bits follow the beat through the pipeline; terms of inactive sources drop out.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.run && src_use;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Exact accumulation of the terms.
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (s5_valid_ff) begin
         acc_in = acc_ff + ACC_W'(s5_term_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // New alpha: zero for an inactive cell, the emission on a first symbol, otherwise the saturated sum.
   always_comb begin
      acc_sat = (acc_ff[ACC_W-1:AW] != '0) ? '1 : acc_ff[AW-1:0];
      if (!cell_active) begin
         new_alpha = '0;
      end else if (ctl.first) begin
         new_alpha = AW'(emis_b);
      end else begin
         new_alpha = acc_sat;
      end
   end

   // Alpha register: written back, rescaled, or passed round the ring.
   always_comb begin
      alpha_in_nx = alpha_ff;
      if (ctl.wb) begin
         alpha_in_nx = new_alpha;
      end else if (ctl.rescale) begin
         alpha_in_nx = alpha_ff << SCALE_SHIFT;
      end else if (ctl.rotate) begin
         alpha_in_nx = alpha_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
      end else begin
         alpha_ff <= alpha_in_nx;
      end
   end

   assign alpha_out = alpha_ff;

endmodule

// ===== sv/hmm_scaled_forward_recursion_unit.sv =====
// Scaled forward recursion of a hidden Markov model, one observed symbol per beat.
// Top level: sequencer, ring of hsfr_cell, sum and rescale. Depends on hsfr_pkg
// and hmm_scaled_forward_recursion_unit_macros.svh.
//
// A load beat writes one transition or emission entry and returns nothing. An
// observe beat returns one result. It passes the emission read, then, unless
// first_symbol is set, one turn of the alpha ring through all N_STATES cells to
// form the products and the drain of the five-stage product pipeline in each
// cell; then the write-back, a second ring turn to add up the alpha sum, the
// rescale step and the result register.
// One observe beat is worked on at a time; the next beat is taken while a
// finished result still waits in the output register.
module hmm_scaled_forward_recursion_unit #(
   parameter int N_STATES    = 8,
   parameter int N_SYMBOLS   = 16,
   parameter int SCALE_SHIFT = 16,
   parameter int PROB_BITS   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hsfr_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [hsfr_pkg::ROW_W-1:0]        req_row_state,
   input  logic [hsfr_pkg::COL_W-1:0]        req_column_index,
   input  logic [31:0]                       req_prob_value,
   input  logic [hsfr_pkg::SYM_W-1:0]        req_symbol,
   input  logic                              req_first_symbol,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hsfr_pkg::SCALE_W-1:0]      rsp_scale_total,
   output logic [PROB_BITS+7:0]              rsp_alpha_sum,
   output logic                              rsp_rescaled,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hsfr_pkg::CSR_W-1:0]        csr_states_in_use
);

   localparam int PB     = PROB_BITS;
   localparam int AW     = PROB_BITS + 8;
   localparam int KW     = $clog2(N_STATES);
   localparam int NW     = $clog2(N_STATES + 1);
   localparam int SA_W   = $clog2(N_SYMBOLS);
   localparam int SUM_W  = AW + KW;
   localparam int CNT_W  = $clog2((N_STATES > hsfr_pkg::PIPE_DEPTH) ?
                                  N_STATES : hsfr_pkg::PIPE_DEPTH);
   localparam bit SS_GE_PB = SCALE_SHIFT >= PROB_BITS;
   localparam int THR_SH   = SS_GE_PB ? 0 : PROB_BITS - SCALE_SHIFT;

   hsfr_pkg::state_type    state_ff, state_in;
   hsfr_pkg::cell_ctl_type ctl;

   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         first_ff;
   logic [SA_W-1:0]              sym_ff;
   logic                         sym_ok_ff;
   logic [hsfr_pkg::CSR_W-1:0]   csr_n_ff;
   logic [NW-1:0]                n_active;
   logic [hsfr_pkg::SCALE_W-1:0] scale_cnt_ff, scale_cnt_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [AW-1:0]                sum_sat;
   logic                         sum_low;
   logic                         resc;
   logic [AW-1:0]                res_sum_ff;
   logic                         res_resc_ff;
   logic                         req_acc;
   logic                         is_observe;
   logic                         cnt_last_ring;
   logic                         cnt_last_pipe;
   logic                         out_load;
   logic                         rsp_valid_ff;
   logic [hsfr_pkg::SCALE_W-1:0] rsp_scale_ff;
   logic [AW-1:0]                rsp_sum_ff;
   logic                         rsp_resc_ff;
   logic [AW-1:0]                ring [N_STATES];

   assign req_acc       = req_valid && !req_stall;
   assign is_observe    = req_opcode == hsfr_pkg::OP_OBSERVE;
   assign cnt_last_ring = 32'(cnt_ff) == N_STATES - 1;
   assign cnt_last_pipe = 32'(cnt_ff) == hsfr_pkg::PIPE_DEPTH - 1;
   assign out_load      = (state_ff == hsfr_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Active state count, clamped to one and to N_STATES.
   always_comb begin
      if (csr_n_ff == '0) begin
         n_active = NW'(1);
      end else if (32'(csr_n_ff) > N_STATES) begin
         n_active = NW'(N_STATES);
      end else begin
         n_active = NW'(csr_n_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hsfr_pkg::ST_IDLE: begin
            if (req_acc && is_observe) state_in = hsfr_pkg::ST_EMIS;
         end
         hsfr_pkg::ST_EMIS: begin
            state_in = first_ff ? hsfr_pkg::ST_WB : hsfr_pkg::ST_RUN;
         end
         hsfr_pkg::ST_RUN: begin
            if (cnt_last_ring) state_in = hsfr_pkg::ST_DRAIN;
         end
         hsfr_pkg::ST_DRAIN: begin
            if (cnt_last_pipe) state_in = hsfr_pkg::ST_WB;
         end
         hsfr_pkg::ST_WB: begin
            state_in = hsfr_pkg::ST_SUM;
         end
         hsfr_pkg::ST_SUM: begin
            if (cnt_last_ring) state_in = hsfr_pkg::ST_SCALE;
         end
         hsfr_pkg::ST_SCALE: begin
            state_in = hsfr_pkg::ST_OUT;
         end
         hsfr_pkg::ST_OUT: begin
            if (out_load) state_in = hsfr_pkg::ST_IDLE;
         end
         default: begin
            state_in = hsfr_pkg::ST_IDLE;
         end
      endcase
   end

   // Step counter for the ring turns and the pipeline drain.
   always_comb begin
      cnt_in = '0;
      case (state_ff)
         hsfr_pkg::ST_RUN,
         hsfr_pkg::ST_SUM: begin
            cnt_in = cnt_last_ring ? '0 : cnt_ff + CNT_W'(1);
         end
         hsfr_pkg::ST_DRAIN: begin
            cnt_in = cnt_last_pipe ? '0 : cnt_ff + CNT_W'(1);
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Sum threshold and rescale decision.
   always_comb begin
      sum_sat = (sum_ff[SUM_W-1:AW] != '0) ? '1 : sum_ff[AW-1:0];
      if (SS_GE_PB) begin
         sum_low = sum_sat == '0;
      end else begin
         sum_low = sum_sat < (AW'(1) << THR_SH);
      end
      resc = !first_ff && sum_low;
   end

   // Outputs of the sequencer: handshakes and the cell control beat.
   always_comb begin
      req_stall     = state_ff != hsfr_pkg::ST_IDLE;
      csr_ready     = state_ff == hsfr_pkg::ST_IDLE;
      ctl           = '0;
      ctl.load_tran = req_acc && (req_opcode == hsfr_pkg::OP_LOAD_TRAN) &&
                      (32'(req_row_state) < N_STATES) && (32'(req_column_index) < N_STATES);
      ctl.load_emis = req_acc && (req_opcode == hsfr_pkg::OP_LOAD_EMIS) &&
                      (32'(req_row_state) < N_STATES) && (32'(req_column_index) < N_SYMBOLS);
      ctl.emis_rd   = state_ff == hsfr_pkg::ST_EMIS;
      ctl.clear     = state_ff == hsfr_pkg::ST_EMIS;
      ctl.run       = state_ff == hsfr_pkg::ST_RUN;
      ctl.rotate    = (state_ff == hsfr_pkg::ST_RUN) || (state_ff == hsfr_pkg::ST_SUM);
      ctl.wb        = state_ff == hsfr_pkg::ST_WB;
      ctl.rescale   = (state_ff == hsfr_pkg::ST_SCALE) && resc;
      ctl.first     = first_ff;
      ctl.sym_ok    = sym_ok_ff;
   end

   // Alpha sum taken from cell zero as the ring turns.
   always_comb begin
      sum_in = sum_ff;
      if (state_ff == hsfr_pkg::ST_EMIS) begin
         sum_in = '0;
      end else if (state_ff == hsfr_pkg::ST_SUM) begin
         sum_in = sum_ff + SUM_W'(ring[0]);
      end
   end

   // Scale count: cleared by a first symbol, saturating otherwise.
   always_comb begin
      scale_cnt_in = scale_cnt_ff;
      if (state_ff == hsfr_pkg::ST_SCALE) begin
         if (first_ff) begin
            scale_cnt_in = '0;
         end else if (resc && (scale_cnt_ff != '1)) begin
            scale_cnt_in = scale_cnt_ff + hsfr_pkg::SCALE_W'(1);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsfr_pkg::ST_IDLE;
         cnt_ff       <= '0;
         csr_n_ff     <= hsfr_pkg::CSR_W'(8);
         scale_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         scale_cnt_ff <= scale_cnt_in;
         if (csr_valid && csr_ready) begin
            csr_n_ff <= csr_states_in_use;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers of the current symbol and of the result.
   always_ff @(posedge clock) begin
      if (req_acc && is_observe) begin
         first_ff  <= req_first_symbol;
         sym_ff    <= SA_W'(req_symbol);
         sym_ok_ff <= 32'(req_symbol) < N_SYMBOLS;
      end
      sum_ff <= sum_in;
      if (state_ff == hsfr_pkg::ST_SCALE) begin
         res_sum_ff  <= resc ? AW'(sum_sat << SCALE_SHIFT) : sum_sat;
         res_resc_ff <= resc;
      end
      if (out_load) begin
         rsp_scale_ff <= scale_cnt_ff;
         rsp_sum_ff   <= res_sum_ff;
         rsp_resc_ff  <= res_resc_ff;
      end
   end

   // Ring of cells, one per destination state; alpha moves towards cell zero.
   for (genvar g = 0; g < N_STATES; g++) begin : g_cell
      hsfr_cell #(
         .N_STATES    (N_STATES),
         .N_SYMBOLS   (N_SYMBOLS),
         .SCALE_SHIFT (SCALE_SHIFT),
         .PROB_BITS   (PROB_BITS),
         .CELL_IDX    (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .step_k    (KW'(cnt_ff)),
         .n_active  (n_active),
         .wr_row    (req_row_state),
         .wr_col    (req_column_index),
         .wr_prob   (PB'(req_prob_value)),
         .rd_sym    (sym_ff),
         .alpha_in  (ring[(g + 1) % N_STATES]),
         .alpha_out (ring[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scale_total = rsp_scale_ff;
   assign rsp_alpha_sum   = rsp_sum_ff;
   assign rsp_rescaled    = rsp_resc_ff;

   `include "hmm_scaled_forward_recursion_unit_macros.svh"

   // A rescaled beat has counted at least one rescaling.
   `HSFR_ASSERT_IMP(a_resc_counts, clock, reset, rsp_valid && rsp_rescaled, rsp_scale_total != '0, "rescaled beat with zero scale count")
   // A rescaled sum came from below the threshold, so it stays below one.
   `HSFR_ASSERT_IMP(a_resc_range, clock, reset, rsp_valid && rsp_rescaled, rsp_alpha_sum < (AW'(1) << PB), "rescaled sum out of range")
   // An accepted observe beat starts with the emission read.
   `HSFR_ASSERT_NXT(a_obs_start, clock, reset, req_valid && !req_stall && is_observe, state_ff == hsfr_pkg::ST_EMIS, "observe beat did not start")

endmodule

// ===== test/hmm_scaled_forward_recursion_unit_test.sv =====
// Self-checking testbench for the scaled forward recursion unit.
// It predicts every result in its own model and compares the result beats field by field.
// Depends on hsfr_pkg and the top level hmm_scaled_forward_recursion_unit.
`timescale 1ns / 1ps

module hmm_scaled_forward_recursion_unit_test;

   localparam int STATES    = 8;
   localparam int SYMBOLS   = 16;
   localparam int SHIFT     = 16;
   localparam int SUM_W     = 40;
   localparam int SETTLE    = 40;
   localparam logic [hsfr_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [63:0] ALPHA_TOP = (64'd1 << SUM_W) - 1;

   typedef struct packed {
      logic [hsfr_pkg::SCALE_W-1:0] scale_total;
      logic [SUM_W-1:0]             alpha_sum;
      logic                         rescaled;
   } step_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [hsfr_pkg::OPCODE_W-1:0] req_opcode;
   logic [hsfr_pkg::ROW_W-1:0]    req_row_state;
   logic [hsfr_pkg::COL_W-1:0]    req_column_index;
   logic [31:0]                   req_prob_value;
   logic [hsfr_pkg::SYM_W-1:0]    req_symbol;
   logic                          req_first_symbol;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [hsfr_pkg::SCALE_W-1:0]  rsp_scale_total;
   logic [SUM_W-1:0]              rsp_alpha_sum;
   logic                          rsp_rescaled;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [hsfr_pkg::CSR_W-1:0]    csr_states_in_use;

   // Shadow state of the recursion.
   logic [31:0]                  tran_shadow [STATES*STATES];
   logic [31:0]                  emis_shadow [STATES*SYMBOLS];
   logic [63:0]                  alpha_shadow [STATES];
   logic [hsfr_pkg::SCALE_W-1:0] scale_shadow;
   logic [hsfr_pkg::CSR_W-1:0]   states_shadow;

   step_result_type pending_results[$];
   int unsigned     error_count;
   int unsigned     send_gap_pct;
   int unsigned     stall_pct;
   int unsigned     hold_cycles;

   hmm_scaled_forward_recursion_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Guard against a hang.
   initial begin
      #4ms;
      $display("** hmm_scaled_forward_recursion_unit: FAILED **");
      $finish;
   end

   // Product of an alpha with a Q0.32 probability, truncated and saturated to the alpha range.
   function automatic logic [63:0] q_product(logic [63:0] x, logic [31:0] y);
      logic [95:0] p;
      logic [63:0] r;
      p = {32'd0, x} * {64'd0, y};
      r = p[95:32];
      return (r > ALPHA_TOP) ? ALPHA_TOP : r;
   endfunction

   // Advance the shadow recursion by one observed symbol and return its result.
   function automatic step_result_type forward_step(logic [hsfr_pkg::SYM_W-1:0] sym,
                                                    logic first);
      step_result_type res;
      logic [63:0] next_alpha [STATES];
      logic [63:0] acc;
      logic [63:0] total;
      int n;
      n = (states_shadow == 0) ? 1 : (states_shadow > STATES) ? STATES : int'(states_shadow);
      total = 0;
      res.rescaled = 1'b0;
      for (int j = 0; j < STATES; j++) begin
         acc = 0;
         if (j < n) begin
            if (first) begin
               acc = {32'd0, emis_shadow[j*SYMBOLS + sym]};
            end else begin
               for (int i = 0; i < n; i++)
                  acc += q_product(q_product(alpha_shadow[i], tran_shadow[i*STATES + j]),
                                   emis_shadow[j*SYMBOLS + sym]);
               if (acc > ALPHA_TOP) acc = ALPHA_TOP;
            end
         end
         next_alpha[j] = acc;
         total += acc;
      end
      if (total > ALPHA_TOP) total = ALPHA_TOP;
      if (first) begin
         scale_shadow = 0;
      end else if (total < (64'd1 << (32 - SHIFT))) begin
         res.rescaled = 1'b1;
         if (scale_shadow != 16'hFFFF) scale_shadow++;
         for (int j = 0; j < n; j++) next_alpha[j] = next_alpha[j] << SHIFT;
         total = total << SHIFT;
      end
      alpha_shadow = next_alpha;
      res.scale_total = scale_shadow;
      res.alpha_sum = total[SUM_W-1:0];
      return res;
   endfunction

   // Offer one request beat, wait for it to be taken, then idle at random.
   task automatic send_beat(logic [hsfr_pkg::OPCODE_W-1:0] op, logic [hsfr_pkg::ROW_W-1:0] row,
                            logic [hsfr_pkg::COL_W-1:0] col, logic [31:0] prob,
                            logic [hsfr_pkg::SYM_W-1:0] sym, logic first);
      int unsigned gap;
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_row_state    <= row;
      req_column_index <= col;
      req_prob_value   <= prob;
      req_symbol       <= sym;
      req_first_symbol <= first;
      do @(posedge clock); while (req_stall);
      case (op)
         hsfr_pkg::OP_LOAD_TRAN: if (col < STATES) tran_shadow[row*STATES + col] = prob;
         hsfr_pkg::OP_LOAD_EMIS: emis_shadow[row*SYMBOLS + col] = prob;
         hsfr_pkg::OP_OBSERVE:   pending_results.push_back(forward_step(sym, first));
         default: ;
      endcase
      gap = 0;
      while ($urandom_range(99) < send_gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic observe(logic [hsfr_pkg::SYM_W-1:0] sym, logic first);
      send_beat(hsfr_pkg::OP_OBSERVE, hsfr_pkg::ROW_W'($urandom), hsfr_pkg::COL_W'($urandom),
                $urandom, sym, first);
   endtask

   // Random probability, weighted towards small values and the extremes.
   function automatic logic [31:0] random_prob();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom >> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // Drain the block, then write the active-state count.
   task automatic write_states(logic [hsfr_pkg::CSR_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_states_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      states_shadow = value;
   endtask

   // Every table entry is written before any observation reads it.
   task automatic fill_tables();
      for (int r = 0; r < STATES; r++)
         for (int c = 0; c < STATES; c++)
            send_beat(hsfr_pkg::OP_LOAD_TRAN, hsfr_pkg::ROW_W'(r), hsfr_pkg::COL_W'(c),
                      random_prob(), hsfr_pkg::SYM_W'($urandom), 1'($urandom));
      for (int r = 0; r < STATES; r++)
         for (int c = 0; c < SYMBOLS; c++)
            send_beat(hsfr_pkg::OP_LOAD_EMIS, hsfr_pkg::ROW_W'(r), hsfr_pkg::COL_W'(c),
                      random_prob(), hsfr_pkg::SYM_W'($urandom), 1'($urandom));
   endtask

   // Loads to columns beyond the state count and the unused opcode change nothing.
   task automatic test_ignored_beats();
      send_beat(hsfr_pkg::OP_LOAD_TRAN, 3'd7, 4'd15, 32'hFFFF_FFFF, 4'd15, 1'b1);
      send_beat(hsfr_pkg::OP_LOAD_TRAN, 3'd0, 4'd8, 32'h0, 4'd0, 1'b0);
      send_beat(OP_UNUSED, 3'd7, 4'd15, 32'hFFFF_FFFF, 4'd15, 1'b1);
      send_beat(OP_UNUSED, 3'd0, 4'd0, 32'h0, 4'd0, 1'b0);
   endtask

   // Later steps with all-zero alpha, then a sequence start at both symbol extremes.
   task automatic test_sequences();
      observe(4'd0, 1'b0);
      observe(4'd15, 1'b0);
      observe(4'd15, 1'b1);
      for (int k = 0; k < 4; k++) observe(hsfr_pkg::SYM_W'($urandom), 1'b0);
      observe(4'd0, 1'b1);
      observe(4'd7, 1'b0);
   endtask

   // Zero emissions for one symbol drive alpha to zero so that each later step rescales.
   task automatic test_zero_alpha();
      for (int r = 0; r < STATES; r++)
         send_beat(hsfr_pkg::OP_LOAD_EMIS, hsfr_pkg::ROW_W'(r), 4'd9, 32'd0, 4'd0, 1'b0);
      observe(4'd9, 1'b1);
      observe(4'd2, 1'b0);
      observe(4'd9, 1'b0);
   endtask

   // Hold the result side off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      hold_cycles = 400;
      observe(hsfr_pkg::SYM_W'($urandom), 1'b1);
      for (int k = 0; k < 10; k++) observe(hsfr_pkg::SYM_W'($urandom), 1'b0);
   endtask

   // Random sequences with interleaved loads and occasional unused opcodes.
   task automatic test_random(int unsigned beats);
      int unsigned sent;
      sent = 0;
      while (sent < beats) begin
         case ($urandom_range(19))
            0: send_beat(hsfr_pkg::OP_LOAD_TRAN, hsfr_pkg::ROW_W'($urandom),
                         hsfr_pkg::COL_W'($urandom), random_prob(),
                         hsfr_pkg::SYM_W'($urandom), 1'($urandom));
            1: send_beat(hsfr_pkg::OP_LOAD_EMIS, hsfr_pkg::ROW_W'($urandom),
                         hsfr_pkg::COL_W'($urandom), random_prob(),
                         hsfr_pkg::SYM_W'($urandom), 1'($urandom));
            2: send_beat(OP_UNUSED, hsfr_pkg::ROW_W'($urandom), hsfr_pkg::COL_W'($urandom),
                         $urandom, hsfr_pkg::SYM_W'($urandom), 1'($urandom));
            3: observe(hsfr_pkg::SYM_W'($urandom), 1'b1);
            default: observe(hsfr_pkg::SYM_W'($urandom), 1'b0);
         endcase
         sent++;
      end
   endtask

   // Result side: check each beat against the oldest expectation and drive stall.
   initial begin
      step_result_type want;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result beat: scale %0d sum %h rescaled %b", $time,
                        rsp_scale_total, rsp_alpha_sum, rsp_rescaled);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_scale_total !== want.scale_total) begin
                  $display("%0t: scale_total expected %0d actual %0d", $time,
                           want.scale_total, rsp_scale_total);
                  error_count++;
               end
               if (rsp_alpha_sum !== want.alpha_sum) begin
                  $display("%0t: alpha_sum expected %h actual %h", $time,
                           want.alpha_sum, rsp_alpha_sum);
                  error_count++;
               end
               if (rsp_rescaled !== want.rescaled) begin
                  $display("%0t: rescaled expected %b actual %b", $time,
                           want.rescaled, rsp_rescaled);
                  error_count++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Main sequence.
   initial begin
      error_count       = 0;
      send_gap_pct      = 0;
      stall_pct         = 0;
      hold_cycles       = 0;
      states_shadow     = 4'd8;
      scale_shadow      = 0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = hsfr_pkg::OP_LOAD_TRAN;
      req_row_state     = 0;
      req_column_index  = 0;
      req_prob_value    = 0;
      req_symbol        = 0;
      req_first_symbol  = 1'b0;
      csr_valid         = 1'b0;
      csr_states_in_use = 4'd8;
      for (int k = 0; k < STATES; k++) alpha_shadow[k] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fill_tables();
      test_ignored_beats();
      test_sequences();
      write_states(4'd1);
      test_sequences();
      write_states(4'd0);
      test_sequences();
      write_states(4'd15);
      test_zero_alpha();
      test_backpressure();

      write_states(4'd8);
      test_random(80);
      write_states(4'd3);
      send_gap_pct = 45;
      test_random(75);
      write_states(4'd5);
      send_gap_pct = 0;
      stall_pct    = 45;
      test_random(75);
      write_states(4'd2);
      send_gap_pct = 6;
      stall_pct    = 6;
      test_random(75);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("** hmm_scaled_forward_recursion_unit: PASSED **");
      else
         $display("** hmm_scaled_forward_recursion_unit: FAILED **");
      $finish;
   end

endmodule
